// File: rtl/sad_pkg.sv
`timescale 1ns / 1ps
package sad_pkg;

	// Default sizes for the top-level parameters
	localparam int MAX_RADIUS_DEF    = 7;
	localparam int MAX_DISPARITY_DEF = 64;
	localparam int MAX_WIDTH_DEF     = 1024;

	// Fixed field widths
	localparam int PIX_W   = 8;
	localparam int COST_W  = 16;   // 255 * 225 fits
	localparam int ROW_W   = 12;   // row index 0..4095
	localparam int HGT_W   = 13;   // height value 1..4096
	localparam int MOD_W   = 4;    // remainder of row by 2r+1
	localparam int RAD_W   = 3;
	localparam int CNT_W   = 7;
	localparam int WID_W   = 11;
	localparam int CFG_W   = 13;
	localparam int CIDX_W  = 2;
	localparam int DISP_W  = 6;
	localparam int MAX_HEIGHT = 4096;

	// Configuration register indexes
	typedef enum logic [CIDX_W-1:0] {
		REG_RADIUS = 2'd0,
		REG_COUNT  = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} cfg_reg_t;

	// Input item kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// Control broadcast to every cell of the chain
	typedef struct packed {
		logic clr;
		logic shift;
		logic acc;
		logic drain;
	} cell_ctrl_t;

endpackage

// File: rtl/sad_in_if.sv
`timescale 1ns / 1ps
interface sad_in_if;
	logic                        valid;
	logic                        ready;
	logic                        action;
	logic [sad_pkg::PIX_W-1:0]   left_pixel;
	logic [sad_pkg::PIX_W-1:0]   right_pixel;

	modport source (output valid, output action, output left_pixel, output right_pixel,
		input ready);
	modport sink (input valid, input action, input left_pixel, input right_pixel,
		output ready);
endinterface

// File: rtl/sad_out_if.sv
`timescale 1ns / 1ps
interface sad_out_if;
	logic                        valid;
	logic                        ready;
	logic [sad_pkg::DISP_W-1:0]  disparity;
	logic                        frame_end;
	logic                        last_of_run;

	modport source (output valid, output disparity, output frame_end, output last_of_run,
		input ready);
	modport sink (input valid, input disparity, input frame_end, input last_of_run,
		output ready);
endinterface

// File: rtl/sad_mod.sv
`timescale 1ns / 1ps
// Bit-serial remainder of a row number by the window side, one bit per cycle
module sad_mod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sad_pkg::ROW_W-1:0]   dividend,
	input  logic [sad_pkg::MOD_W-1:0]   divisor,
	output logic                        done,
	output logic [sad_pkg::MOD_W-1:0]   rem
);
	localparam int CW = $clog2(sad_pkg::ROW_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [sad_pkg::ROW_W-1:0]   num_q;
	logic [sad_pkg::MOD_W-1:0]   rem_q;
	logic [sad_pkg::MOD_W-1:0]   div_q;
	logic [sad_pkg::MOD_W:0]     shifted;
	logic [sad_pkg::MOD_W:0]     reduced;

	// restoring step: bring in next bit, subtract when it fits
	assign shifted = {rem_q, num_q[sad_pkg::ROW_W-1]};
	assign reduced = (shifted >= {1'b0, div_q}) ? shifted - {1'b0, div_q} : shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(sad_pkg::ROW_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= reduced[sad_pkg::MOD_W-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

// File: rtl/sad_cell.sv
`timescale 1ns / 1ps
// One disparity cell: holds a right pixel of the shift line and its window cost
module sad_cell (
	input  logic                        clk,
	input  sad_pkg::cell_ctrl_t         ctrl,
	input  logic [sad_pkg::PIX_W-1:0]   left_pixel,
	input  logic [sad_pkg::PIX_W-1:0]   right_in,
	output logic [sad_pkg::PIX_W-1:0]   right_out,
	input  logic [sad_pkg::COST_W-1:0]  cost_in,
	output logic [sad_pkg::COST_W-1:0]  cost_out
);
	logic [sad_pkg::PIX_W-1:0]   right_q;
	logic [sad_pkg::COST_W-1:0]  cost_q;
	logic [sad_pkg::PIX_W-1:0]   diff;

	// compare against the pixel arriving from the neighbor
	assign diff = (left_pixel > right_in) ? left_pixel - right_in : right_in - left_pixel;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			right_q <= right_in;
		end
		if (ctrl.clr) begin
			cost_q <= '0;
		end else if (ctrl.acc) begin
			cost_q <= cost_q + sad_pkg::COST_W'(diff);
		end else if (ctrl.drain) begin
			cost_q <= cost_in;
		end
	end

	assign right_out = right_q;
	assign cost_out  = cost_q;
endmodule

// File: rtl/sad_stereo_disparity.sv
`timescale 1ns / 1ps
// Channel   Dir  Type        Payload
// pixels    in   sad_in_if   action, left_pixel, right_pixel
// results   out  sad_out_if  disparity, frame_end, last_of_run
// cfg_*     in   write port  cfg_index selects radius/count/width/height
//
// A pixel item computes its row-slot remainder, then writes the line store.
// Each result takes one window row per sweep of the line store read port through
// the disparity cell chain, then a drain of nd costs to the minimum compare.
// Reset clears the control state; line stores are not cleared.
// A stalled results channel holds the next finished result until taken;
// the input is taken only while the sequencer is idle.
module sad_stereo_disparity #(
	parameter int MAX_RADIUS    = sad_pkg::MAX_RADIUS_DEF,
	parameter int MAX_DISPARITY = sad_pkg::MAX_DISPARITY_DEF,
	parameter int MAX_WIDTH     = sad_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [sad_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [sad_pkg::CFG_W-1:0]   cfg_data,
	sad_in_if.sink                      pixels,
	sad_out_if.source                   results
);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int NSLOT = 2 * MAX_RADIUS + 1;
	localparam int DEPTH = NSLOT * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int DW    = $clog2(MAX_DISPARITY + 1);
	localparam int IW    = (DW > sad_pkg::DISP_W) ? DW : sad_pkg::DISP_W;
	localparam int KW    = $clog2(2 * MAX_RADIUS + MAX_DISPARITY + 1);
	localparam int TW    = ((CW > KW) ? CW : KW) + 2;
	localparam int PW    = $clog2(7 * MAX_WIDTH + 1);
	localparam int RW    = sad_pkg::ROW_W;
	localparam int HW    = sad_pkg::HGT_W;
	localparam int PXW   = sad_pkg::PIX_W;

	typedef enum logic [3:0] {
		S_IDLE, S_WMOD, S_RROW, S_RMOD, S_SWEEP, S_RNEXT, S_DRAIN, S_OUT
	} state_t;

	// configuration registers
	logic [sad_pkg::RAD_W-1:0]  cfg_radius_q;
	logic [sad_pkg::CNT_W-1:0]  cfg_count_q;
	logic [sad_pkg::WID_W-1:0]  cfg_width_q;
	logic [HW-1:0]              cfg_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_radius_q <= sad_pkg::RAD_W'(2);
			cfg_count_q  <= sad_pkg::CNT_W'(64);
			cfg_width_q  <= sad_pkg::WID_W'(640);
			cfg_height_q <= HW'(480);
		end else if (cfg_we) begin
			case (cfg_index)
				sad_pkg::REG_RADIUS: cfg_radius_q <= cfg_data[sad_pkg::RAD_W-1:0];
				sad_pkg::REG_COUNT:  cfg_count_q  <= cfg_data[sad_pkg::CNT_W-1:0];
				sad_pkg::REG_WIDTH:  cfg_width_q  <= cfg_data[sad_pkg::WID_W-1:0];
				sad_pkg::REG_HEIGHT: cfg_height_q <= cfg_data[HW-1:0];
				default: ;
			endcase
		end
	end

	// effective (saturated) settings
	logic [sad_pkg::RAD_W-1:0]  r;
	logic [DW-1:0]              nd;
	logic [WW-1:0]              w_eff;
	logic [HW-1:0]              h_eff;
	logic [CW-1:0]              w_m1;
	logic [RW-1:0]              h_m1;

	always_comb begin
		r = (5'(cfg_radius_q) > 5'(MAX_RADIUS)) ? sad_pkg::RAD_W'(MAX_RADIUS) : cfg_radius_q;
		if (cfg_count_q == '0) nd = DW'(1);
		else if (9'(cfg_count_q) > 9'(MAX_DISPARITY)) nd = DW'(MAX_DISPARITY);
		else nd = DW'(cfg_count_q);
		if (cfg_width_q == '0) w_eff = WW'(1);
		else if (13'(cfg_width_q) > 13'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
		else w_eff = WW'(cfg_width_q);
		if (cfg_height_q == '0) h_eff = HW'(1);
		else if (cfg_height_q > HW'(sad_pkg::MAX_HEIGHT)) h_eff = HW'(sad_pkg::MAX_HEIGHT);
		else h_eff = cfg_height_q;
		w_m1 = CW'(w_eff - WW'(1));
		h_m1 = RW'(h_eff - HW'(1));
	end

	// sequencer state
	state_t                     state_q;
	logic [RW-1:0]              in_row_q;
	logic [CW-1:0]              in_col_q;
	logic [HW-1:0]              out_row_q;
	logic [CW-1:0]              out_col_q;
	logic [PW-1:0]              pending_q;
	logic [RW-1:0]              y_q;
	logic [CW-1:0]              x_q;
	logic [PXW-1:0]             lpix_q;
	logic [PXW-1:0]             rpix_q;
	logic [RW-1:0]              cur_oy_q;
	logic [CW-1:0]              cur_ox_q;
	logic [CW-1:0]              last_col_q;
	logic [3:0]                 dy_q;
	logic [KW-1:0]              k_q;
	logic [DW-1:0]              j_q;
	logic [sad_pkg::MOD_W-1:0]  slot_q;
	logic [sad_pkg::COST_W-1:0] best_cost_q;
	logic [IW-1:0]              best_q;
	logic                       mod_start_q;
	logic [RW-1:0]              mod_num_q;
	logic                       shift_s1;
	logic                       acc_s1;
	logic                       out_valid_q;
	logic [sad_pkg::DISP_W-1:0] out_disp_q;
	logic                       out_end_q;
	logic                       out_last_q;

	logic                       mod_done;
	logic [sad_pkg::MOD_W-1:0]  mod_rem;
	logic                       in_accept;
	logic                       out_free;

	assign in_accept = pixels.valid && pixels.ready;
	assign out_free  = !out_valid_q || results.ready;

	// row-slot remainder unit
	sad_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start_q),
		.dividend (mod_num_q),
		.divisor  ({r, 1'b1}),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	// position of the incoming pixel, clamped to the frame
	logic [RW-1:0] y_in;
	logic [CW-1:0] x_in;
	assign y_in = (in_row_q > h_m1) ? h_m1 : in_row_q;
	assign x_in = (in_col_q > w_m1) ? w_m1 : in_col_q;

	// emission range for the pixel just stored
	logic          x_ge_r;
	logic          x_last;
	logic          emit_any;
	logic [CW-1:0] first_col;
	logic [CW-1:0] last_col;
	logic          h_gt_r;
	logic [2:0]    tail_rows;
	always_comb begin
		x_ge_r    = x_q >= CW'(r);
		x_last    = x_q == w_m1;
		emit_any  = (y_q >= RW'(r)) && (x_ge_r || x_last);
		first_col = x_ge_r ? x_q - CW'(r) : '0;
		last_col  = x_last ? w_m1 : x_q - CW'(r);
		h_gt_r    = h_eff > HW'(r);
		tail_rows = h_gt_r ? r : h_eff[2:0];
	end

	// window row of the current sweep, clamped
	logic signed [RW+1:0] row_s;
	logic [RW-1:0]        row_c;
	always_comb begin
		row_s = (RW+2)'(cur_oy_q) + (RW+2)'(dy_q) - (RW+2)'(r);
		if (row_s < 0) row_c = '0;
		else if (row_s > $signed((RW+2)'(h_m1))) row_c = h_m1;
		else row_c = RW'(row_s);
	end

	// column of the current sweep step, clamped
	logic signed [TW-1:0] t_s;
	logic [CW-1:0]        col_c;
	always_comb begin
		t_s = TW'(cur_ox_q) - TW'(r) - TW'(nd) + TW'(1) + TW'(k_q);
		if (t_s < 0) col_c = '0;
		else if (t_s > $signed(TW'(w_m1))) col_c = w_m1;
		else col_c = CW'(t_s);
	end

	logic [KW-1:0] sweep_end;
	logic [KW-1:0] acc_start;
	assign sweep_end = KW'(2 * r) + KW'(nd) - KW'(1);
	assign acc_start = KW'(nd) - KW'(1);

	// cost chain head
	logic [sad_pkg::COST_W-1:0] cost_chain [MAX_DISPARITY+1];
	logic [PXW-1:0]             right_chain [MAX_DISPARITY+1];

	// main sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_row_q    <= '0;
			in_col_q    <= '0;
			out_row_q   <= '0;
			out_col_q   <= '0;
			pending_q   <= '0;
			mod_start_q <= 1'b0;
			shift_s1    <= 1'b0;
			acc_s1      <= 1'b0;
			out_valid_q <= 1'b0;
			dy_q        <= '0;
			k_q         <= '0;
			j_q         <= '0;
		end else begin
			mod_start_q <= 1'b0;
			shift_s1    <= 1'b0;
			acc_s1      <= 1'b0;
			if (results.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (pixels.action == sad_pkg::ACT_PIXEL) begin
							pending_q   <= '0;
							mod_num_q   <= y_in;
							mod_start_q <= 1'b1;
							state_q     <= S_WMOD;
						end else if (pending_q != '0) begin
							if (out_row_q >= h_eff || WW'(out_col_q) >= w_eff) begin
								pending_q <= '0;
							end else begin
								cur_oy_q   <= RW'(out_row_q);
								cur_ox_q   <= out_col_q;
								last_col_q <= out_col_q;
								if (out_col_q == w_m1) begin
									out_row_q <= out_row_q + 1'b1;
									out_col_q <= '0;
								end else begin
									out_col_q <= out_col_q + 1'b1;
								end
								pending_q <= pending_q - 1'b1;
								dy_q      <= '0;
								state_q   <= S_RROW;
							end
						end
					end
				end
				S_WMOD: begin
					if (mod_done) begin
						if (emit_any) begin
							cur_oy_q   <= y_q - RW'(r);
							cur_ox_q   <= first_col;
							last_col_q <= last_col;
							if (last_col == w_m1) begin
								out_row_q <= HW'(y_q - RW'(r)) + 1'b1;
								out_col_q <= '0;
							end else begin
								out_row_q <= HW'(y_q - RW'(r));
								out_col_q <= last_col + 1'b1;
							end
							dy_q    <= '0;
							state_q <= S_RROW;
						end else begin
							state_q <= S_IDLE;
						end
						if (x_last) begin
							in_col_q <= '0;
							if (y_q == h_m1) begin
								in_row_q  <= '0;
								out_row_q <= h_gt_r ? h_eff - HW'(r) : '0;
								out_col_q <= '0;
								pending_q <= PW'(tail_rows) * PW'(w_eff);
							end else begin
								in_row_q <= y_q + 1'b1;
							end
						end else begin
							in_col_q <= x_q + 1'b1;
						end
					end
				end
				S_RROW: begin
					mod_num_q   <= row_c;
					mod_start_q <= 1'b1;
					state_q     <= S_RMOD;
				end
				S_RMOD: begin
					if (mod_done) begin
						slot_q  <= mod_rem;
						k_q     <= '0;
						state_q <= S_SWEEP;
					end
				end
				S_SWEEP: begin
					shift_s1 <= 1'b1;
					acc_s1   <= k_q >= acc_start;
					if (k_q == sweep_end) state_q <= S_RNEXT;
					else k_q <= k_q + 1'b1;
				end
				S_RNEXT: begin
					if (dy_q == {r, 1'b0}) begin
						j_q     <= '0;
						state_q <= S_DRAIN;
					end else begin
						dy_q    <= dy_q + 1'b1;
						state_q <= S_RROW;
					end
				end
				S_DRAIN: begin
					if (j_q == '0 || cost_chain[0] < best_cost_q) begin
						best_cost_q <= cost_chain[0];
						best_q      <= IW'(j_q);
					end
					if (j_q == nd - DW'(1)) state_q <= S_OUT;
					else j_q <= j_q + 1'b1;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_disp_q  <= best_q[sad_pkg::DISP_W-1:0];
						out_end_q   <= (cur_oy_q == h_m1) && (cur_ox_q == w_m1);
						out_last_q  <= cur_ox_q == last_col_q;
						if (cur_ox_q == last_col_q) begin
							state_q <= S_IDLE;
						end else begin
							cur_ox_q <= cur_ox_q + 1'b1;
							dy_q     <= '0;
							state_q  <= S_RROW;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			y_q    <= y_in;
			x_q    <= x_in;
			lpix_q <= pixels.left_pixel;
			rpix_q <= pixels.right_pixel;
		end
	end

	// line stores: one write port, one registered read port
	logic [PXW-1:0] left_mem  [DEPTH];
	logic [PXW-1:0] right_mem [DEPTH];
	logic [PXW-1:0] l_rd_s1;
	logic [PXW-1:0] r_rd_s1;
	logic [AW-1:0]  waddr;
	logic [AW-1:0]  raddr;
	logic           mem_we;

	assign mem_we = (state_q == S_WMOD) && mod_done;
	assign waddr  = AW'(mod_rem) * AW'(MAX_WIDTH) + AW'(x_q);
	assign raddr  = AW'(slot_q) * AW'(MAX_WIDTH) + AW'(col_c);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			left_mem[waddr]  <= lpix_q;
			right_mem[waddr] <= rpix_q;
		end
		if (state_q == S_SWEEP) begin
			l_rd_s1 <= left_mem[raddr];
			r_rd_s1 <= right_mem[raddr];
		end
	end

	// disparity cell chain: right pixels move up, costs drain down to cell 0
	sad_pkg::cell_ctrl_t cell_ctrl;
	always_comb begin
		cell_ctrl.clr   = (state_q == S_RROW) && (dy_q == '0);
		cell_ctrl.shift = shift_s1;
		cell_ctrl.acc   = acc_s1;
		cell_ctrl.drain = state_q == S_DRAIN;
	end

	assign right_chain[0]             = r_rd_s1;
	assign cost_chain[MAX_DISPARITY]  = '0;

	for (genvar g = 0; g < MAX_DISPARITY; g++) begin : g_cell
		sad_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.left_pixel (l_rd_s1),
			.right_in   (right_chain[g]),
			.right_out  (right_chain[g+1]),
			.cost_in    (cost_chain[g+1]),
			.cost_out   (cost_chain[g])
		);
	end

	// channel outputs
	assign pixels.ready        = state_q == S_IDLE;
	assign results.valid       = out_valid_q;
	assign results.disparity   = out_disp_q;
	assign results.frame_end   = out_end_q;
	assign results.last_of_run = out_last_q;
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import sad_pkg::*;

	localparam int STORE_SLOTS = 15 * 1024;
	localparam int STALL_LIMIT = 20000;
	localparam int SETTLE = 60;

	typedef struct {
		logic [DISP_W-1:0] disparity;
		bit                frame_end;
		bit                last_of_run;
	} match_t;

	// Scoreboard: disparity predictor plus queue of owed results
	class disparity_board;
		byte unsigned lstore[STORE_SLOTS];
		byte unsigned rstore[STORE_SLOTS];
		int unsigned in_row, in_col, out_row, out_col, owed;
		int unsigned radius, count, width, height;
		match_t due[$];
		int errors;
		int taken;

		function new();
			radius = 2; count = 64; width = 640; height = 480;
		endfunction

		function void set_reg(cfg_reg_t idx, int unsigned val);
			case (idx)
				REG_RADIUS: radius = val & 7;
				REG_COUNT:  count = val & 127;
				REG_WIDTH:  width = val & 2047;
				default:    height = val & 8191;
			endcase
		endfunction

		function int eff_r();
			return radius > 7 ? 7 : radius;
		endfunction
		function int eff_d();
			return count < 1 ? 1 : (count > 64 ? 64 : count);
		endfunction
		function int eff_w();
			return width < 1 ? 1 : (width > 1024 ? 1024 : width);
		endfunction
		function int eff_h();
			return height < 1 ? 1 : (height > 4096 ? 4096 : height);
		endfunction

		function int clip(int v, int hi);
			return v < 0 ? 0 : (v > hi ? hi : v);
		endfunction

		function int slot(int row, int col, int r);
			int idx;
			idx = (row % (2 * r + 1)) * 1024 + col;
			return idx < STORE_SLOTS ? idx : 0;
		endfunction

		// Lowest-cost shift for output pixel (oy, ox), first one on ties
		function match_t match_at(int oy, int ox, int w, int h);
			int r, nd, row, a, b;
			int unsigned cost, best_cost;
			match_t m;
			r = eff_r(); nd = eff_d();
			best_cost = 0;
			m.disparity = '0;
			for (int d = 0; d < nd; d++) begin
				cost = 0;
				for (int dy = -r; dy <= r; dy++) begin
					row = clip(oy + dy, h - 1);
					for (int dx = -r; dx <= r; dx++) begin
						a = lstore[slot(row, clip(ox + dx, w - 1), r)];
						b = rstore[slot(row, clip(ox - d + dx, w - 1), r)];
						cost += a > b ? a - b : b - a;
					end
				end
				if (d == 0 || cost < best_cost) begin
					best_cost = cost;
					m.disparity = d;
				end
			end
			m.frame_end = (oy == h - 1 && ox == w - 1);
			m.last_of_run = 0;
			return m;
		endfunction

		// Accepted input transaction: update state, queue its results
		function void note(bit act, byte unsigned lp, byte unsigned rp);
			int r, w, h, y, x, oy, first, last, idx;
			match_t m;
			match_t run[$];
			r = eff_r(); w = eff_w(); h = eff_h();
			if (act == ACT_FLUSH) begin
				if (owed == 0)
					return;
				oy = out_row;
				if (oy >= h || out_col >= w) begin
					owed = 0;
					return;
				end
				m = match_at(oy, out_col, w, h);
				m.last_of_run = 1;
				due.push_back(m);
				if (out_col + 1 >= w) begin
					out_col = 0;
					out_row = oy + 1;
				end else
					out_col++;
				owed--;
				return;
			end
			owed = 0;
			y = in_row > h - 1 ? h - 1 : in_row;
			x = in_col > w - 1 ? w - 1 : in_col;
			idx = slot(y, x, r);
			lstore[idx] = lp;
			rstore[idx] = rp;
			if (y >= r) begin
				oy = y - r; first = -1; last = -1;
				if (x >= r) begin
					first = x - r; last = x - r;
				end
				if (x == w - 1) begin
					if (first < 0) first = 0;
					last = w - 1;
				end
				if (first >= 0) begin
					for (int c = first; c <= last; c++)
						run.push_back(match_at(oy, c, w, h));
					if (last + 1 >= w) begin
						out_row = oy + 1; out_col = 0;
					end else begin
						out_row = oy; out_col = last + 1;
					end
				end
			end
			if (x == w - 1) begin
				in_col = 0;
				if (y == h - 1) begin
					in_row = 0;
					out_row = h > r ? h - r : 0;
					out_col = 0;
					owed = (h - out_row) * w;
				end else
					in_row = y + 1;
			end else
				in_col = x + 1;
			if (run.size() > 0)
				run[run.size() - 1].last_of_run = 1;
			foreach (run[i])
				due.push_back(run[i]);
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("ERROR @%0t: %s", $realtime, what);
		endtask

		// Accepted result transaction against the oldest expectation
		task check(logic [DISP_W-1:0] disp, logic fe, logic lor);
			match_t e;
			taken++;
			if (due.size() == 0) begin
				report("result with nothing owed");
				return;
			end
			e = due.pop_front();
			if (disp !== e.disparity)
				report($sformatf("disparity %0d, wanted %0d", disp, e.disparity));
			if (fe !== e.frame_end)
				report($sformatf("frame_end %0b, wanted %0b", fe, e.frame_end));
			if (lor !== e.last_of_run)
				report($sformatf("last_of_run %0b, wanted %0b", lor, e.last_of_run));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CIDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	sad_in_if pix();
	sad_out_if res();

	sad_stereo_disparity i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pixels(pix.sink),
		.results(res.source)
	);

	disparity_board board = new();
	bit calm;
	bit held;
	int items;
	int quiet_cycles;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Send one input transaction, with a random gap before it
	task send(bit act, byte unsigned lp, byte unsigned rp);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid <= 1'b1;
		pix.action <= act;
		pix.left_pixel <= lp;
		pix.right_pixel <= rp;
		do @(posedge clk); while (!pix.ready);
		if (act == ACT_PIXEL || board.owed > 0)
			items++;
		board.note(act, lp, rp);
	endtask

	// Hold input until all owed results are out and the block has settled
	task drain_out();
		pix.valid <= 1'b0;
		while (board.due.size() > 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task set_regs(int unsigned r, int unsigned nd, int unsigned w, int unsigned h);
		cfg_reg_t idx[4];
		int unsigned val[4];
		idx = '{REG_RADIUS, REG_COUNT, REG_WIDTH, REG_HEIGHT};
		val = '{r, nd, w, h};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			board.set_reg(idx[i], val[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// One frame: about half the right image is the left shifted by a random offset, or fixed patterns with extremes
	task run_frame(bit extremes);
		int w, h, s, n, pick;
		byte unsigned lf[], rt[];
		w = board.eff_w(); h = board.eff_h();
		s = $urandom_range(0, board.eff_d());
		lf = new[w * h];
		rt = new[w * h];
		foreach (lf[i])
			lf[i] = extremes ? ((i % 3 == 0) ? 8'd255 : 8'd0) : $urandom_range(0, 255);
		foreach (rt[i]) begin
			if (extremes)
				rt[i] = (i % 2 == 0) ? 8'd0 : 8'd255;
			else if ($urandom_range(0, 1))
				rt[i] = lf[(i / w) * w + ((i % w) + s >= w ? w - 1 : (i % w) + s)];
			else
				rt[i] = $urandom_range(0, 255);
		end
		for (int i = 0; i < w * h; i++) begin
			// stray flush mid-frame produces nothing
			if (!extremes && $urandom_range(0, 30) == 0)
				send(ACT_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255));
			send(ACT_PIXEL, lf[i], rt[i]);
		end
		pick = $urandom_range(0, 9);
		if (extremes || pick < 7)
			n = board.owed + (extremes ? 1 : $urandom_range(0, 2));
		else if (pick < 9)
			n = $urandom_range(0, board.owed);
		else
			n = 0;
		for (int i = 0; i < n; i++)
			send(ACT_FLUSH, $urandom_range(0, 255), $urandom_range(0, 255));
	endtask

	// Result side: random stalls, plus one long hold-off
	initial begin
		int gap;
		res.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			gap = calm ? 0 : $urandom_range(0, 8);
			if (!held && board.taken == 40) begin
				held = 1;
				gap = 400;
			end
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!res.valid);
			board.check(res.disparity, res.frame_end, res.last_of_run);
		end
	end

	// Watchdog on cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("sad_stereo_disparity: mismatch");
			$finish;
		end
	end

	initial begin
		quiet_cycles = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_RADIUS;
		cfg_data <= '0;
		pix.valid <= 1'b0;
		pix.action <= ACT_PIXEL;
		pix.left_pixel <= '0;
		pix.right_pixel <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extreme pixels, full flush plus one flush with nothing owed
		calm = 0;
		set_regs(1, 4, 4, 3);
		run_frame(1);
		drain_out();
		// widest saturated row, zero count, zero radius
		calm = 1;
		set_regs(0, 0, 2047, 1);
		run_frame(0);
		drain_out();
		// largest radius and saturated count on an image smaller than the window
		calm = 0;
		set_regs(7, 100, 3, 2);
		run_frame(0);
		drain_out();
		set_regs(7, 64, 2, 3);
		run_frame(0);

		// random phases of whole frames
		while (items < 1440) begin
			drain_out();
			calm = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 9) == 0)
				set_regs($urandom_range(3, 7), $urandom_range(0, 127),
					$urandom_range(0, 4), $urandom_range(0, 3));
			else
				set_regs($urandom_range(0, 2), $urandom_range(0, 12),
					$urandom_range(0, 10), $urandom_range(0, 8));
			repeat ($urandom_range(1, 3))
				run_frame(0);
		end

		drain_out();
		if (board.errors == 0 && board.due.size() == 0)
			$display("sad_stereo_disparity: match");
		else
			$display("sad_stereo_disparity: mismatch");
		$finish;
	end
endmodule

// File: filelist.f
rtl/sad_pkg.sv
rtl/sad_in_if.sv
rtl/sad_out_if.sv
rtl/sad_mod.sv
rtl/sad_cell.sv
rtl/sad_stereo_disparity.sv
tb/tb_top.sv
